@@ rtl/core/nor_seq_pkg.sv @@
package nor_seq_pkg;

   // field widths
   localparam int ADDR_W   = 25;
   localparam int LEN_W    = 16;
   localparam int BYTE_W   = 8;
   localparam int OP_W     = 4;
   localparam int CS_W     = 4;
   localparam int IDX_W    = 3;

   // packed port widths
   localparam int REQ_DATA_W = 56;
   localparam int REQ_USER_W = 4;
   localparam int RSP_DATA_W = 16;
   localparam int RSP_USER_W = 2;

   // page quotient by reciprocal: estimate is exact or one low
   localparam int RECIP_SHIFT = 30;
   localparam int RECIP_W     = 27;
   localparam int PROD_W      = ADDR_W + RECIP_W;

   // parameter defaults
   localparam int PAGE_BYTES_DEF = 256;
   localparam int CHIP_COUNT_DEF = 4;
   localparam int CHIP_SHIFT_DEF = 23;

   // request opcodes
   localparam logic [OP_W-1:0] OP_READ         = 4'd0;
   localparam logic [OP_W-1:0] OP_PAGE_READ    = 4'd1;
   localparam logic [OP_W-1:0] OP_PAGE_PROGRAM = 4'd2;
   localparam logic [OP_W-1:0] OP_SECTOR_ERASE = 4'd3;
   localparam logic [OP_W-1:0] OP_BULK_ERASE   = 4'd4;
   localparam logic [OP_W-1:0] OP_WRITE_ENABLE = 4'd5;
   localparam logic [OP_W-1:0] OP_READ_STATUS  = 4'd6;
   localparam logic [OP_W-1:0] OP_WRITE_STATUS = 4'd7;
   localparam logic [OP_W-1:0] OP_READ_ID      = 4'd8;
   localparam logic [OP_W-1:0] OP_DATA         = 4'd9;

   // flash instruction bytes
   localparam logic [BYTE_W-1:0] CMD_WREN    = 8'h06;
   localparam logic [BYTE_W-1:0] CMD_RDID    = 8'h9F;
   localparam logic [BYTE_W-1:0] CMD_RDSR    = 8'h05;
   localparam logic [BYTE_W-1:0] CMD_WRSR    = 8'h01;
   localparam logic [BYTE_W-1:0] CMD_READ    = 8'h03;
   localparam logic [BYTE_W-1:0] CMD_PP      = 8'h02;
   localparam logic [BYTE_W-1:0] CMD_SE      = 8'hD8;
   localparam logic [BYTE_W-1:0] CMD_BE      = 8'hC7;
   localparam logic [BYTE_W-1:0] DUMMY_BYTE  = 8'hFF;

   typedef struct packed {
      logic [OP_W-1:0]   opcode;
      logic [ADDR_W-1:0] address;
      logic [LEN_W-1:0]  length;
      logic [BYTE_W-1:0] data_byte;
   } item_type;

   typedef struct packed {
      logic              frame_open;
      logic [LEN_W-1:0]  bytes_left;
      logic              reading;
      logic [CS_W-1:0]   active_select;
   } state_type;

   typedef struct packed {
      logic [BYTE_W-1:0] tx_byte;
      logic [CS_W-1:0]   chip_select;
      logic              capture;
      logic              frame_end;
      logic              last;
   } entry_type;

endpackage

@@ rtl/core/nor_seq_decode.sv @@
module nor_seq_decode #(
   parameter int PAGE_BYTES = nor_seq_pkg::PAGE_BYTES_DEF,
   parameter int CHIP_COUNT = nor_seq_pkg::CHIP_COUNT_DEF,
   parameter int CHIP_SHIFT = nor_seq_pkg::CHIP_SHIFT_DEF
) (
   input  nor_seq_pkg::item_type              item,
   input  logic [nor_seq_pkg::ADDR_W-1:0]     quot,
   input  logic [nor_seq_pkg::IDX_W-1:0]      idx,
   input  nor_seq_pkg::state_type             state,
   output nor_seq_pkg::entry_type             entry,
   output logic                               drop,
   output nor_seq_pkg::state_type             next_state
);

   localparam int AW = nor_seq_pkg::ADDR_W;

   logic [AW-1:0]                     page_est;
   logic [AW-1:0]                     page_rem;
   logic [AW-1:0]                     page;
   logic [AW-1:0]                     chip_idx;
   logic [nor_seq_pkg::CS_W-1:0]      cs;
   logic [nor_seq_pkg::BYTE_W-1:0]    a_hi, a_mid, a_lo, p_hi, p_mid, p_lo;
   logic                              len_zero;

   function automatic nor_seq_pkg::entry_type mk(
      input logic [nor_seq_pkg::BYTE_W-1:0] tx,
      input logic [nor_seq_pkg::CS_W-1:0]   sel,
      input logic                           cap,
      input logic                           fend,
      input logic                           lst
   );
      nor_seq_pkg::entry_type e;
      e.tx_byte     = tx;
      e.chip_select = sel;
      e.capture     = cap;
      e.frame_end   = fend;
      e.last        = lst;
      return e;
   endfunction

   // finish the page round-down: quotient estimate may be one low
   assign page_est = AW'(quot * AW'(PAGE_BYTES));
   assign page_rem = item.address - page_est;
   assign page     = (page_rem >= AW'(PAGE_BYTES)) ? page_est + AW'(PAGE_BYTES) : page_est;

   // one-hot chip select from the high address bits
   assign chip_idx = item.address >> CHIP_SHIFT;
   assign cs = (chip_idx < AW'(CHIP_COUNT)) ? (nor_seq_pkg::CS_W'(1) << chip_idx[1:0])
                                            : '0;

   assign a_hi  = item.address[23:16];
   assign a_mid = item.address[15:8];
   assign a_lo  = item.address[7:0];
   assign p_hi  = page[23:16];
   assign p_mid = page[15:8];
   assign p_lo  = page[7:0];
   assign len_zero = (item.length == '0);

   // pick the byte at this position of the command and the state it leaves
   always_comb begin
      entry      = mk('0, '0, 1'b0, 1'b0, 1'b0);
      drop       = 1'b0;
      next_state = state;
      if (item.opcode == nor_seq_pkg::OP_DATA) begin
         if (!state.frame_open) begin
            drop = 1'b1;
         end else begin
            entry = mk(state.reading ? nor_seq_pkg::DUMMY_BYTE : item.data_byte,
                       state.active_select, state.reading,
                       state.bytes_left == nor_seq_pkg::LEN_W'(1), 1'b1);
            next_state.bytes_left = state.bytes_left - nor_seq_pkg::LEN_W'(1);
            if (state.bytes_left == nor_seq_pkg::LEN_W'(1)) begin
               next_state.frame_open = 1'b0;
            end
         end
      end else if (state.frame_open) begin
         drop = 1'b1;
      end else begin
         case (item.opcode)
            nor_seq_pkg::OP_READ: begin
               case (idx)
                  3'd0:    entry = mk(nor_seq_pkg::CMD_READ, cs, 1'b0, 1'b0, 1'b0);
                  3'd1:    entry = mk(a_hi, cs, 1'b0, 1'b0, 1'b0);
                  3'd2:    entry = mk(a_mid, cs, 1'b0, 1'b0, 1'b0);
                  default: entry = mk(a_lo, cs, 1'b0, len_zero, 1'b1);
               endcase
               if (!len_zero) begin
                  next_state.frame_open    = 1'b1;
                  next_state.bytes_left    = item.length;
                  next_state.reading       = 1'b1;
                  next_state.active_select = cs;
               end
            end
            nor_seq_pkg::OP_PAGE_READ: begin
               case (idx)
                  3'd0:    entry = mk(nor_seq_pkg::CMD_READ, cs, 1'b0, 1'b0, 1'b0);
                  3'd1:    entry = mk(p_hi, cs, 1'b0, 1'b0, 1'b0);
                  3'd2:    entry = mk(p_mid, cs, 1'b0, 1'b0, 1'b0);
                  default: entry = mk(p_lo, cs, 1'b0, 1'b0, 1'b1);
               endcase
               next_state.frame_open    = 1'b1;
               next_state.bytes_left    = nor_seq_pkg::LEN_W'(PAGE_BYTES);
               next_state.reading       = 1'b1;
               next_state.active_select = cs;
            end
            nor_seq_pkg::OP_PAGE_PROGRAM: begin
               case (idx)
                  3'd0:    entry = mk(nor_seq_pkg::CMD_WREN, cs, 1'b0, 1'b1, 1'b0);
                  3'd1:    entry = mk(nor_seq_pkg::CMD_PP, cs, 1'b0, 1'b0, 1'b0);
                  3'd2:    entry = mk(p_hi, cs, 1'b0, 1'b0, 1'b0);
                  3'd3:    entry = mk(p_mid, cs, 1'b0, 1'b0, 1'b0);
                  default: entry = mk(p_lo, cs, 1'b0, 1'b0, 1'b1);
               endcase
               next_state.frame_open    = 1'b1;
               next_state.bytes_left    = nor_seq_pkg::LEN_W'(PAGE_BYTES);
               next_state.reading       = 1'b0;
               next_state.active_select = cs;
            end
            nor_seq_pkg::OP_SECTOR_ERASE: begin
               case (idx)
                  3'd0:    entry = mk(nor_seq_pkg::CMD_WREN, cs, 1'b0, 1'b1, 1'b0);
                  3'd1:    entry = mk(nor_seq_pkg::CMD_SE, cs, 1'b0, 1'b0, 1'b0);
                  3'd2:    entry = mk(a_hi, cs, 1'b0, 1'b0, 1'b0);
                  3'd3:    entry = mk('0, cs, 1'b0, 1'b0, 1'b0);
                  default: entry = mk('0, cs, 1'b0, 1'b1, 1'b1);
               endcase
            end
            nor_seq_pkg::OP_BULK_ERASE: begin
               case (idx)
                  3'd0:    entry = mk(nor_seq_pkg::CMD_WREN, cs, 1'b0, 1'b1, 1'b0);
                  default: entry = mk(nor_seq_pkg::CMD_BE, cs, 1'b0, 1'b1, 1'b1);
               endcase
            end
            nor_seq_pkg::OP_WRITE_ENABLE: begin
               entry = mk(nor_seq_pkg::CMD_WREN, cs, 1'b0, 1'b1, 1'b1);
            end
            nor_seq_pkg::OP_READ_STATUS: begin
               case (idx)
                  3'd0:    entry = mk(nor_seq_pkg::CMD_RDSR, cs, 1'b0, 1'b0, 1'b0);
                  default: entry = mk(nor_seq_pkg::DUMMY_BYTE, cs, 1'b1, 1'b1, 1'b1);
               endcase
            end
            nor_seq_pkg::OP_WRITE_STATUS: begin
               case (idx)
                  3'd0:    entry = mk(nor_seq_pkg::CMD_WREN, cs, 1'b0, 1'b1, 1'b0);
                  3'd1:    entry = mk(nor_seq_pkg::CMD_WRSR, cs, 1'b0, 1'b0, 1'b0);
                  default: entry = mk(item.data_byte, cs, 1'b0, 1'b1, 1'b1);
               endcase
            end
            nor_seq_pkg::OP_READ_ID: begin
               case (idx)
                  3'd0:    entry = mk(nor_seq_pkg::CMD_RDID, cs, 1'b0, 1'b0, 1'b0);
                  3'd1:    entry = mk(nor_seq_pkg::DUMMY_BYTE, cs, 1'b1, 1'b0, 1'b0);
                  3'd2:    entry = mk(nor_seq_pkg::DUMMY_BYTE, cs, 1'b1, 1'b0, 1'b0);
                  default: entry = mk(nor_seq_pkg::DUMMY_BYTE, cs, 1'b1, 1'b1, 1'b1);
               endcase
            end
            default: begin
               drop = 1'b1;
            end
         endcase
      end
   end

endmodule

@@ rtl/core/nor_seq_out.sv @@
module nor_seq_out (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    push,
   input  nor_seq_pkg::entry_type                  entry,
   output logic                                    can_load,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output logic [nor_seq_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic [nor_seq_pkg::RSP_USER_W-1:0]      rsp_tuser,
   output logic                                    rsp_tlast
);

   logic                   valid_ff, valid_in;
   nor_seq_pkg::entry_type word_ff;

   // load whenever the register is empty or its word leaves this cycle
   assign can_load = !valid_ff || rsp_tready;
   assign valid_in = push ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         word_ff <= entry;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {4'b0, word_ff.chip_select, word_ff.tx_byte};
   assign rsp_tuser  = {word_ff.frame_end, word_ff.capture};
   assign rsp_tlast  = word_ff.last;

endmodule

@@ rtl/core/spi_nor_flash_command_sequencer.sv @@
// SPI NOR command sequencer for up to four flash chips. Each request word is
// a flash command or one data-phase byte; each response word is one SPI byte
// with its one-hot chip select, a capture flag for the returned byte and a
// flag that releases chip select after it. A data word yields one response
// word, so data phases stream at one byte per clock while rsp_tready holds. A
// command yields one response word per frame byte it produces (one to five,
// write enable frames included), walked out by the byte-index counter that
// steps the held command through the decoder; the next request is taken in the
// cycle its last byte moves to the response register. Commands arriving while
// a data phase is open, data words with no open frame and unknown opcodes are
// swallowed with no response.
module spi_nor_flash_command_sequencer #(
   parameter int PAGE_BYTES = nor_seq_pkg::PAGE_BYTES_DEF,
   parameter int CHIP_COUNT = nor_seq_pkg::CHIP_COUNT_DEF,
   parameter int CHIP_SHIFT = nor_seq_pkg::CHIP_SHIFT_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // address[24:0], length[40:25], data_byte[48:41], zero fill
   input  logic [nor_seq_pkg::REQ_DATA_W-1:0]      req_tdata,
   // opcode[3:0]
   input  logic [nor_seq_pkg::REQ_USER_W-1:0]      req_tuser,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // tx_byte[7:0], chip_select[11:8], zero fill
   output logic [nor_seq_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // capture[0], frame_end[1]
   output logic [nor_seq_pkg::RSP_USER_W-1:0]      rsp_tuser,
   output logic                                    rsp_tlast
);

   localparam int AW = nor_seq_pkg::ADDR_W;
   localparam logic [nor_seq_pkg::RECIP_W-1:0] RECIP =
      nor_seq_pkg::RECIP_W'((64'd1 << nor_seq_pkg::RECIP_SHIFT) / PAGE_BYTES);

   logic                                hold_valid_ff, hold_valid_in;
   nor_seq_pkg::item_type               item_ff, item_in;
   logic [AW-1:0]                       quot_ff, quot_in;
   logic [nor_seq_pkg::PROD_W-1:0]      prod;
   logic [nor_seq_pkg::IDX_W-1:0]       idx_ff, idx_in;
   nor_seq_pkg::state_type              state_ff, state_in, next_state;
   nor_seq_pkg::entry_type              entry;
   logic                                drop;
   logic                                can_load;
   logic                                push;
   logic                                done;
   logic                                accept;

   // unpack the request word
   assign item_in.opcode    = req_tuser;
   assign item_in.address   = req_tdata[24:0];
   assign item_in.length    = req_tdata[40:25];
   assign item_in.data_byte = req_tdata[48:41];

   // page quotient estimate, finished in the decoder
   assign prod    = nor_seq_pkg::PROD_W'(item_in.address) * nor_seq_pkg::PROD_W'(RECIP);
   assign quot_in = AW'(prod >> nor_seq_pkg::RECIP_SHIFT);

   nor_seq_decode #(
      .PAGE_BYTES (PAGE_BYTES),
      .CHIP_COUNT (CHIP_COUNT),
      .CHIP_SHIFT (CHIP_SHIFT)
   ) u_decode (
      .item       (item_ff),
      .quot       (quot_ff),
      .idx        (idx_ff),
      .state      (state_ff),
      .entry      (entry),
      .drop       (drop),
      .next_state (next_state)
   );

   nor_seq_out u_out (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .entry      (entry),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // a held word is done when swallowed or when its last byte moves out
   assign push       = hold_valid_ff && !drop && can_load;
   assign done       = hold_valid_ff && (drop || (can_load && entry.last));
   assign req_tready = !hold_valid_ff || done;
   assign accept     = req_tvalid && req_tready;

   assign hold_valid_in = accept ? 1'b1 : (done ? 1'b0 : hold_valid_ff);

   // advance the byte index, restart it with each new word
   always_comb begin
      idx_in = idx_ff;
      if (accept || (push && entry.last)) begin
         idx_in = '0;
      end else if (push) begin
         idx_in = idx_ff + nor_seq_pkg::IDX_W'(1);
      end
   end

   // commit frame state with the last byte of a word
   assign state_in = (push && entry.last) ? next_state : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         idx_ff        <= '0;
         state_ff      <= '0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         idx_ff        <= idx_in;
         state_ff      <= state_in;
      end
   end

   // hold the accepted word
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
         quot_ff <= quot_in;
      end
   end

endmodule

@@ tb/tb_spi_nor_flash_command_sequencer.sv @@
module tb_spi_nor_flash_command_sequencer;

   localparam int PAGE_BYTES = nor_seq_pkg::PAGE_BYTES_DEF;
   localparam int CHIP_COUNT = nor_seq_pkg::CHIP_COUNT_DEF;
   localparam int CHIP_SHIFT = nor_seq_pkg::CHIP_SHIFT_DEF;
   localparam int REQ_FILL_W = nor_seq_pkg::REQ_DATA_W - nor_seq_pkg::ADDR_W
                               - nor_seq_pkg::LEN_W - nor_seq_pkg::BYTE_W;

   logic                                  clock = 1'b0;
   logic                                  reset = 1'b1;
   logic                                  req_tvalid = 1'b0;
   logic                                  req_tready;
   logic [nor_seq_pkg::REQ_DATA_W-1:0]    req_tdata = '0;
   logic [nor_seq_pkg::REQ_USER_W-1:0]    req_tuser = '0;
   logic                                  rsp_tvalid;
   logic                                  rsp_tready = 1'b0;
   logic [nor_seq_pkg::RSP_DATA_W-1:0]    rsp_tdata;
   logic [nor_seq_pkg::RSP_USER_W-1:0]    rsp_tuser;
   logic                                  rsp_tlast;

   spi_nor_flash_command_sequencer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // request words waiting to be sent, SPI bytes waiting to come out
   nor_seq_pkg::item_type  pending_reqs [$];
   nor_seq_pkg::entry_type spi_bytes_expected [$];
   nor_seq_pkg::item_type  req_word;

   // sequencer state as seen by the predictor
   logic                             seq_frame_open = 1'b0;
   logic [nor_seq_pkg::LEN_W-1:0]    seq_bytes_left = '0;
   logic                             seq_reading = 1'b0;
   logic [nor_seq_pkg::CS_W-1:0]     seq_active_cs = '0;

   // request generator bookkeeping
   logic              gen_open = 1'b0;
   int                gen_left = 0;
   int                busy_items = 0;

   int                mismatches = 0;
   int                cyc = 0;
   int                bytes_seen = 0;
   int                hold_left = 0;
   logic              hold_done = 1'b0;
   logic              quiet;
   logic              stall_hold;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) cyc <= cyc + 1;

   // no idling on either side inside this window
   assign quiet = (cyc >= 600) && (cyc < 900);

   // append one SPI byte to the expected stream
   task automatic emit(input logic [nor_seq_pkg::BYTE_W-1:0] tx,
                       input logic [nor_seq_pkg::CS_W-1:0] cs,
                       input logic cap, input logic fend);
      nor_seq_pkg::entry_type e;
      e.tx_byte     = tx;
      e.chip_select = cs;
      e.capture     = cap;
      e.frame_end   = fend;
      e.last        = 1'b0;
      spi_bytes_expected.push_back(e);
   endtask

   // expand one accepted request word into the SPI bytes it produces
   task automatic sequence_command(input nor_seq_pkg::item_type it);
      int                                idx;
      logic [nor_seq_pkg::CS_W-1:0]      cs;
      logic [nor_seq_pkg::ADDR_W-1:0]    page;
      nor_seq_pkg::entry_type            e;
      idx  = int'(it.address) >> CHIP_SHIFT;
      cs   = (idx < CHIP_COUNT && idx < 4) ? nor_seq_pkg::CS_W'(1 << idx) : '0;
      page = nor_seq_pkg::ADDR_W'((int'(it.address) / PAGE_BYTES) * PAGE_BYTES);

      // data phase: one byte per word, last one releases the chip
      if (it.opcode == nor_seq_pkg::OP_DATA) begin
         if (!seq_frame_open) return;
         seq_bytes_left = seq_bytes_left - 1'b1;
         emit(seq_reading ? nor_seq_pkg::DUMMY_BYTE : it.data_byte, seq_active_cs,
              seq_reading, seq_bytes_left == 0);
         if (seq_bytes_left == 0) seq_frame_open = 1'b0;
      end else begin
         // drop commands while a frame is open and unknown opcodes
         if (seq_frame_open || it.opcode > nor_seq_pkg::OP_DATA) return;
         case (it.opcode)
            nor_seq_pkg::OP_READ: begin
               emit(nor_seq_pkg::CMD_READ, cs, 1'b0, 1'b0);
               emit(it.address[23:16], cs, 1'b0, 1'b0);
               emit(it.address[15:8], cs, 1'b0, 1'b0);
               emit(it.address[7:0], cs, 1'b0, it.length == 0);
               if (it.length != 0) begin
                  seq_frame_open = 1'b1;
                  seq_bytes_left = it.length;
                  seq_reading    = 1'b1;
                  seq_active_cs  = cs;
               end
            end
            nor_seq_pkg::OP_PAGE_READ, nor_seq_pkg::OP_PAGE_PROGRAM: begin
               if (it.opcode == nor_seq_pkg::OP_PAGE_PROGRAM)
                  emit(nor_seq_pkg::CMD_WREN, cs, 1'b0, 1'b1);
               emit(it.opcode == nor_seq_pkg::OP_PAGE_READ ? nor_seq_pkg::CMD_READ
                                                           : nor_seq_pkg::CMD_PP,
                    cs, 1'b0, 1'b0);
               emit(page[23:16], cs, 1'b0, 1'b0);
               emit(page[15:8], cs, 1'b0, 1'b0);
               emit(page[7:0], cs, 1'b0, 1'b0);
               seq_frame_open = 1'b1;
               seq_bytes_left = nor_seq_pkg::LEN_W'(PAGE_BYTES);
               seq_reading    = (it.opcode == nor_seq_pkg::OP_PAGE_READ);
               seq_active_cs  = cs;
            end
            nor_seq_pkg::OP_SECTOR_ERASE: begin
               emit(nor_seq_pkg::CMD_WREN, cs, 1'b0, 1'b1);
               emit(nor_seq_pkg::CMD_SE, cs, 1'b0, 1'b0);
               emit(it.address[23:16], cs, 1'b0, 1'b0);
               emit(8'h00, cs, 1'b0, 1'b0);
               emit(8'h00, cs, 1'b0, 1'b1);
            end
            nor_seq_pkg::OP_BULK_ERASE: begin
               emit(nor_seq_pkg::CMD_WREN, cs, 1'b0, 1'b1);
               emit(nor_seq_pkg::CMD_BE, cs, 1'b0, 1'b1);
            end
            nor_seq_pkg::OP_WRITE_ENABLE: emit(nor_seq_pkg::CMD_WREN, cs, 1'b0, 1'b1);
            nor_seq_pkg::OP_READ_STATUS: begin
               emit(nor_seq_pkg::CMD_RDSR, cs, 1'b0, 1'b0);
               emit(nor_seq_pkg::DUMMY_BYTE, cs, 1'b1, 1'b1);
            end
            nor_seq_pkg::OP_WRITE_STATUS: begin
               emit(nor_seq_pkg::CMD_WREN, cs, 1'b0, 1'b1);
               emit(nor_seq_pkg::CMD_WRSR, cs, 1'b0, 1'b0);
               emit(it.data_byte, cs, 1'b0, 1'b1);
            end
            default: begin
               emit(nor_seq_pkg::CMD_RDID, cs, 1'b0, 1'b0);
               emit(nor_seq_pkg::DUMMY_BYTE, cs, 1'b1, 1'b0);
               emit(nor_seq_pkg::DUMMY_BYTE, cs, 1'b1, 1'b0);
               emit(nor_seq_pkg::DUMMY_BYTE, cs, 1'b1, 1'b1);
            end
         endcase
      end

      // mark the final byte of this word
      e = spi_bytes_expected.pop_back();
      e.last = 1'b1;
      spi_bytes_expected.push_back(e);
   endtask

   // queue one request word and track whether it opens or closes a frame
   task automatic issue(input logic [nor_seq_pkg::OP_W-1:0] op,
                        input logic [nor_seq_pkg::ADDR_W-1:0] addr,
                        input logic [nor_seq_pkg::LEN_W-1:0] len,
                        input logic [nor_seq_pkg::BYTE_W-1:0] db);
      nor_seq_pkg::item_type it;
      it.opcode    = op;
      it.address   = addr;
      it.length    = len;
      it.data_byte = db;
      pending_reqs.push_back(it);
      if (op == nor_seq_pkg::OP_DATA) begin
         if (gen_open) begin
            busy_items++;
            gen_left--;
            if (gen_left == 0) gen_open = 1'b0;
         end
      end else if (!gen_open && op < nor_seq_pkg::OP_DATA) begin
         busy_items++;
         if (op == nor_seq_pkg::OP_READ && len != 0) begin
            gen_open = 1'b1;
            gen_left = len;
         end else if (op == nor_seq_pkg::OP_PAGE_READ ||
                      op == nor_seq_pkg::OP_PAGE_PROGRAM) begin
            gen_open = 1'b1;
            gen_left = PAGE_BYTES;
         end
      end
   endtask

   // feed the open data phase to its end, with stray commands mixed in
   task automatic fill_data_phase();
      while (gen_open) begin
         if ($urandom_range(0, 99) < 6)
            issue(nor_seq_pkg::OP_W'($urandom_range(0, 15)),
                  nor_seq_pkg::ADDR_W'($urandom), nor_seq_pkg::LEN_W'($urandom),
                  nor_seq_pkg::BYTE_W'($urandom));
         else
            issue(nor_seq_pkg::OP_DATA, nor_seq_pkg::ADDR_W'($urandom),
                  nor_seq_pkg::LEN_W'($urandom), nor_seq_pkg::BYTE_W'($urandom));
      end
   endtask

   // request driver: hold each word until taken, idle at random between words
   always @(posedge clock) begin : drive_req
      logic take;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         take = !req_tvalid || req_tready;
         if (req_tvalid && req_tready) sequence_command(req_word);
         if (take) begin
            if (pending_reqs.size() != 0 && (quiet || $urandom_range(0, 99) >= 26)) begin
               req_word = pending_reqs.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {{REQ_FILL_W{1'b0}}, req_word.data_byte, req_word.length,
                              req_word.address};
               req_tuser  <= req_word.opcode;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // one long back-pressure stretch once traffic is flowing
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && bytes_seen >= 60) begin
         hold_left <= 400;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   assign stall_hold = (hold_left != 0);

   // response monitor: compare each SPI byte with the oldest expectation
   always @(posedge clock) begin : watch_rsp
      nor_seq_pkg::entry_type got;
      nor_seq_pkg::entry_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.tx_byte     = rsp_tdata[7:0];
            got.chip_select = rsp_tdata[11:8];
            got.capture     = rsp_tuser[0];
            got.frame_end   = rsp_tuser[1];
            got.last        = rsp_tlast;
            bytes_seen <= bytes_seen + 1;
            if (spi_bytes_expected.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected byte: tx=%h cs=%h cap=%b end=%b last=%b",
                           got.tx_byte, got.chip_select, got.capture, got.frame_end,
                           got.last);
            end else begin
               want = spi_bytes_expected.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("byte %0d: expected tx=%h cs=%h cap=%b end=%b last=%b",
                              bytes_seen, want.tx_byte, want.chip_select, want.capture,
                              want.frame_end, want.last);
                     $display("   got tx=%h cs=%h cap=%b end=%b last=%b",
                              got.tx_byte, got.chip_select, got.capture,
                              got.frame_end, got.last);
                  end
               end
            end
         end
         rsp_tready <= !stall_hold && (quiet || $urandom_range(0, 99) >= 26);
      end
   end

   // stimulus and end of run
   initial begin : stimulus
      int                               r;
      logic [nor_seq_pkg::OP_W-1:0]     op;
      logic [nor_seq_pkg::LEN_W-1:0]    len;

      // ignored words: stray data, unknown opcodes
      issue(nor_seq_pkg::OP_DATA, '0, '0, 8'h5A);
      issue(4'd10, '1, '1, '1);
      issue(4'd15, '0, '0, '0);

      // write enable, status, ID and erase commands on all four chips, mostly at the address extremes
      issue(nor_seq_pkg::OP_WRITE_ENABLE, 25'h0000000, 16'h0000, 8'h00);
      issue(nor_seq_pkg::OP_READ_STATUS, 25'h1FFFFFF, 16'hFFFF, 8'hFF);
      issue(nor_seq_pkg::OP_WRITE_STATUS, 25'h0800000, 16'h0000, 8'hFF);
      issue(nor_seq_pkg::OP_WRITE_STATUS, 25'h1000000, 16'hFFFF, 8'h00);
      issue(nor_seq_pkg::OP_READ_ID, 25'h1234567, 16'h8000, 8'hA5);
      issue(nor_seq_pkg::OP_SECTOR_ERASE, 25'h1FFFFFF, 16'h0001, 8'h00);
      issue(nor_seq_pkg::OP_SECTOR_ERASE, 25'h0000000, 16'h0000, 8'hFF);
      issue(nor_seq_pkg::OP_BULK_ERASE, 25'h1800000, 16'h7FFF, 8'h3C);

      // read of zero length closes on the address
      issue(nor_seq_pkg::OP_READ, 25'h0ABCDEF, 16'h0000, 8'h00);

      // single-byte read with a command and an unknown opcode during the phase
      issue(nor_seq_pkg::OP_READ, 25'h1FFFFFF, 16'h0001, 8'h00);
      issue(nor_seq_pkg::OP_BULK_ERASE, 25'h0000000, 16'h0000, 8'h00);
      issue(4'd12, 25'h0000000, 16'h0000, 8'h00);
      issue(nor_seq_pkg::OP_DATA, 25'h0000000, 16'h0000, 8'hAA);

      // short read
      issue(nor_seq_pkg::OP_READ, 25'h0FFFFFF, 16'h0003, 8'h00);
      issue(nor_seq_pkg::OP_DATA, '0, '0, 8'h00);
      issue(nor_seq_pkg::OP_DATA, '1, '1, 8'hFF);
      issue(nor_seq_pkg::OP_DATA, '0, '0, 8'h81);

      // one full page program
      issue(nor_seq_pkg::OP_PAGE_PROGRAM, nor_seq_pkg::ADDR_W'($urandom),
            nor_seq_pkg::LEN_W'($urandom), nor_seq_pkg::BYTE_W'($urandom));
      fill_data_phase();

      // random command sequences; the reads among them are mostly short
      while (busy_items < 390) begin
         r   = $urandom_range(0, 99);
         len = nor_seq_pkg::LEN_W'($urandom);
         if (r < 35) begin
            op = nor_seq_pkg::OP_READ;
            r  = $urandom_range(0, 19);
            if (r == 0)      len = '0;
            else if (r == 1) len = nor_seq_pkg::LEN_W'($urandom_range(9, 48));
            else             len = nor_seq_pkg::LEN_W'($urandom_range(1, 8));
         end else if (r < 43) begin
            op = $urandom_range(0, 1) ? nor_seq_pkg::OP_DATA
                                      : nor_seq_pkg::OP_W'($urandom_range(10, 15));
         end else begin
            op = nor_seq_pkg::OP_W'($urandom_range(3, 8));
         end
         issue(op, nor_seq_pkg::ADDR_W'($urandom), len, nor_seq_pkg::BYTE_W'($urandom));
         fill_data_phase();
      end

      // page read, left open at the end of the run
      issue(nor_seq_pkg::OP_PAGE_READ, nor_seq_pkg::ADDR_W'($urandom),
            nor_seq_pkg::LEN_W'($urandom), nor_seq_pkg::BYTE_W'($urandom));
      repeat (6)
         issue(nor_seq_pkg::OP_DATA, nor_seq_pkg::ADDR_W'($urandom),
               nor_seq_pkg::LEN_W'($urandom), nor_seq_pkg::BYTE_W'($urandom));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // drain requests, then expectations, then allow for in-flight bytes
      while (pending_reqs.size() != 0 || req_tvalid) @(posedge clock);
      while (spi_bytes_expected.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin : watchdog
      #4000000;
      $display("Mismatches found");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/nor_seq_pkg.sv
rtl/core/nor_seq_decode.sv
rtl/core/nor_seq_out.sv
rtl/core/spi_nor_flash_command_sequencer.sv
tb/tb_spi_nor_flash_command_sequencer.sv
